### rtl/uricd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uricd_pkg: shared types and helpers for the URI percent codec
// Character classes, hex tables and the job record passed front to back.
// ----------------------------------------------------------------------------
package uricd_pkg;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// Characters
	localparam logic [7:0] ESC_CHAR = 8'h25;

	// Status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_BAD_RAW = 2'd1;
	localparam logic [1:0] ST_BAD_HEX = 2'd2;
	localparam logic [1:0] ST_TRUNC   = 2'd3;

	// Mode register values
	localparam logic MODE_DECODE = 1'b0;
	localparam logic MODE_ENCODE = 1'b1;

	// Position inside an escape while decoding
	typedef enum logic [1:0] {
		ESC_IDLE = 2'd0,
		ESC_PCT  = 2'd1,
		ESC_HI   = 2'd2
	} esc_t;

	// Output position inside an encoded triple
	localparam logic [1:0] PH_PCT = 2'd0;
	localparam logic [1:0] PH_HI  = 2'd1;
	localparam logic [1:0] PH_LO  = 2'd2;

	// One job from front to back: a single result, or an escape triple
	typedef struct packed {
		logic       enc;    // expand to '%' plus two hex digits of data
		logic [7:0] data;
		logic       valid;
		logic       done;
		logic [1:0] status;
	} job_t;

	localparam logic [7:0] HEX_UPPER [16] = '{
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
	};

	function automatic logic is_alnum(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
		       (c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic is_unreserved(input logic [7:0] c);
		return is_alnum(c) || c == 8'h2D || c == 8'h2E || c == 8'h5F || c == 8'h7E;
	endfunction

	function automatic logic is_allowed_raw(input logic [7:0] c);
		return is_unreserved(c) || c == 8'h21 || c == 8'h24 || c == 8'h27 ||
		       c == 8'h28 || c == 8'h29 || c == 8'h2A || c == 8'h2B ||
		       c == 8'h2C || c == 8'h3B || c == 8'h3A || c == 8'h40 ||
		       c == 8'h2F || c == 8'h3F;
	endfunction

	// Bit 4 set when c is not a hex digit
	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		logic [7:0] t;
		t = 8'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			t = c - 8'h30;
			return {1'b0, t[3:0]};
		end
		if (c >= 8'h41 && c <= 8'h46) begin
			t = c - 8'h37;
			return {1'b0, t[3:0]};
		end
		if (c >= 8'h61 && c <= 8'h66) begin
			t = c - 8'h57;
			return {1'b0, t[3:0]};
		end
		return 5'b10000;
	endfunction

endpackage

### rtl/uricd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uricd_front: input side of the URI percent codec
// Holds the mode and decode state, classifies each item into one job.
// ----------------------------------------------------------------------------
module uricd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               mode_we,
	input  logic               mode_wdata,
	input  logic               accept,
	input  logic [7:0]         in_byte,
	input  logic               value_end,
	output uricd_pkg::job_t    job
);

	logic             mode_q;
	uricd_pkg::esc_t  esc_q, esc_d;
	logic [3:0]       hi_q, hi_d;
	logic [1:0]       status_q, status_d;
	logic [4:0]       digit;

	// Hold mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= uricd_pkg::MODE_DECODE;
		end else if (mode_we) begin
			mode_q <= mode_wdata;
		end
	end

	// Classify the item
	always_comb begin
		esc_d    = esc_q;
		hi_d     = hi_q;
		status_d = status_q;
		digit    = uricd_pkg::hex_nibble(in_byte);
		job      = '0;
		if (mode_q == uricd_pkg::MODE_ENCODE) begin
			job.enc   = !uricd_pkg::is_unreserved(in_byte);
			job.data  = in_byte;
			job.valid = 1'b1;
			job.done  = value_end;
		end else begin
			if (status_q == uricd_pkg::ST_OK) begin
				if (esc_q == uricd_pkg::ESC_IDLE) begin
					if (in_byte == uricd_pkg::ESC_CHAR) begin
						esc_d = uricd_pkg::ESC_PCT;
					end else if (uricd_pkg::is_allowed_raw(in_byte)) begin
						job.data  = in_byte;
						job.valid = 1'b1;
					end else begin
						status_d = uricd_pkg::ST_BAD_RAW;
					end
				end else if (digit[4]) begin
					status_d = uricd_pkg::ST_BAD_HEX;
					esc_d    = uricd_pkg::ESC_IDLE;
				end else if (esc_q == uricd_pkg::ESC_PCT) begin
					hi_d  = digit[3:0];
					esc_d = uricd_pkg::ESC_HI;
				end else begin
					job.data  = {hi_q, digit[3:0]};
					job.valid = 1'b1;
					esc_d     = uricd_pkg::ESC_IDLE;
				end
				// Escape left open at the end of the value
				if (value_end && status_d == uricd_pkg::ST_OK &&
				    esc_d != uricd_pkg::ESC_IDLE) begin
					status_d  = uricd_pkg::ST_TRUNC;
					job.valid = 1'b0;
					job.data  = 8'd0;
				end
			end
			job.done   = value_end;
			job.status = status_d;
		end
	end

	// Advance decode state; clear it at the end of a value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q    <= uricd_pkg::ESC_IDLE;
			hi_q     <= 4'd0;
			status_q <= uricd_pkg::ST_OK;
		end else if (accept) begin
			if (value_end) begin
				esc_q    <= uricd_pkg::ESC_IDLE;
				hi_q     <= 4'd0;
				status_q <= uricd_pkg::ST_OK;
			end else if (mode_q == uricd_pkg::MODE_DECODE) begin
				esc_q    <= esc_d;
				hi_q     <= hi_d;
				status_q <= status_d;
			end
		end
	end

endmodule

### rtl/uricd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uricd_queue: short job queue between front and back
// Register-based first-in first-out store with show-ahead head.
// ----------------------------------------------------------------------------
module uricd_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  uricd_pkg::job_t wr_job,
	input  logic            rd_en,
	output uricd_pkg::job_t head,
	output logic            q_full,
	output logic            q_empty
);

	uricd_pkg::job_t                 slot_q [uricd_pkg::QUEUE_DEPTH];
	logic [uricd_pkg::QUEUE_AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [uricd_pkg::QUEUE_AW:0]    count_q;

	assign q_full  = (count_q == (uricd_pkg::QUEUE_AW+1)'(uricd_pkg::QUEUE_DEPTH));
	assign q_empty = (count_q == '0);
	assign head    = slot_q[rd_ptr_q];

	// Store incoming job
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/uricd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uricd_back: output side of the URI percent codec
// Expands jobs into result items and holds them in the output register.
// ----------------------------------------------------------------------------
module uricd_back (
	input  logic            clk,
	input  logic            arst_n,
	input  uricd_pkg::job_t head,
	input  logic            q_empty,
	output logic            q_pop,
	input  logic            pop,
	output logic            empty,
	output logic [7:0]      out_byte,
	output logic            byte_valid,
	output logic            last_of_run,
	output logic            value_done,
	output logic [1:0]      status
);

	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       bvalid_q, last_q, done_q;
	logic [1:0] status_q;
	logic [1:0] phase_q;
	logic       load;
	logic [7:0] nx_byte;
	logic       nx_bvalid, nx_last, nx_done;
	logic [1:0] nx_status;

	assign load  = (!out_valid_q || pop) && !q_empty;
	assign q_pop = load && nx_last;
	assign empty = !out_valid_q;

	assign out_byte    = byte_q;
	assign byte_valid  = bvalid_q;
	assign last_of_run = last_q;
	assign value_done  = done_q;
	assign status      = status_q;

	// Form the next item from the head job
	always_comb begin
		nx_byte   = head.data;
		nx_bvalid = head.valid;
		nx_last   = 1'b1;
		nx_done   = head.done;
		nx_status = head.status;
		if (head.enc) begin
			nx_bvalid = 1'b1;
			nx_status = uricd_pkg::ST_OK;
			unique case (phase_q)
				uricd_pkg::PH_PCT: begin
					nx_byte = uricd_pkg::ESC_CHAR;
					nx_last = 1'b0;
					nx_done = 1'b0;
				end
				uricd_pkg::PH_HI: begin
					nx_byte = uricd_pkg::HEX_UPPER[head.data[7:4]];
					nx_last = 1'b0;
					nx_done = 1'b0;
				end
				default: begin
					nx_byte = uricd_pkg::HEX_UPPER[head.data[3:0]];
				end
			endcase
		end
	end

	// Advance output valid and triple position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= uricd_pkg::PH_PCT;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				phase_q     <= nx_last ? uricd_pkg::PH_PCT : phase_q + 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hold the item payload
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q   <= nx_byte;
			bvalid_q <= nx_bvalid;
			last_q   <= nx_last;
			done_q   <= nx_done;
			status_q <= nx_status;
		end
	end

endmodule

### rtl/uri_percent_codec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uri_percent_codec: streaming percent decoder / encoder for URI query values
// Top level joining the classifying front, the job queue and the back end.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_byte/value_end and raise push; the item is taken
//   at a clock edge with push high and full low. value_end marks the last
//   byte of a value, after which the decode state starts fresh.
//   Result channel: while empty is low the oldest result sits on out_byte,
//   byte_valid, last_of_run, value_done and status; raise pop to take it.
//   mode (mode_we/mode_wdata) selects decode (0) or encode (1); write it
//   only while no items are in flight.
//   Flow: a taken item is written into the job queue, and the back end then
//   loads its first result into the output register. The back end issues
//   one result per cycle while pop is held high and jobs are queued, so an
//   item gives one result, or three results for an escaped byte in encode
//   mode. A four-entry job queue lets the front keep taking items while the
//   back end is busy or stalled; full rises when it fills, and while pop is
//   low the waiting result holds steady.
//   Reset: arst_n clears mode to decode, the decode state, the queue pointers
//   and the output valid flag (empty high).
// ----------------------------------------------------------------------------
module uri_percent_codec (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       mode_we,
	input  logic       mode_wdata,
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       value_end,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       last_of_run,
	output logic       value_done,
	output logic [1:0] status
);

	uricd_pkg::job_t job, head;
	logic            accept;
	logic            q_pop, q_empty;

	assign accept = push && !full;

	uricd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.mode_we    (mode_we),
		.mode_wdata (mode_wdata),
		.accept     (accept),
		.in_byte    (in_byte),
		.value_end  (value_end),
		.job        (job)
	);

	uricd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept),
		.wr_job  (job),
		.rd_en   (q_pop),
		.head    (head),
		.q_full  (full),
		.q_empty (q_empty)
	);

	uricd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.pop         (pop),
		.empty       (empty),
		.out_byte    (out_byte),
		.byte_valid  (byte_valid),
		.last_of_run (last_of_run),
		.value_done  (value_done),
		.status      (status)
	);

endmodule
